FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

  // default geometry
  localparam int CellsDef   = 2000;
  localparam int ColumnsDef = 80;

  // payload widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int NIB_W  = 4;
  localparam int ATTR_W = 8;
  localparam int LOC_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // special characters and fill attributes
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_CLEAR   = 8'h07;
  localparam logic [ATTR_W-1:0] ATTR_BLANK   = 8'h00;

  // command codes on the input channel
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // operations after decode
  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_WRITE   = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attr;
    logic [LOC_W-1:0]  loc;
    logic              loc_ok;
  } op_t;

endpackage

FILE: rtl/core/tcw_cmd_if.sv
interface tcw_cmd_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [NIB_W-1:0]  foreground;
  logic [NIB_W-1:0]  background;
  logic [LOC_W-1:0]  cell_location;

  modport source (
    output valid, command, char_code, foreground, background, cell_location,
    input  ready
  );

  modport sink (
    input  valid, command, char_code, foreground, background, cell_location,
    output ready
  );

endinterface

FILE: rtl/core/tcw_res_if.sv
interface tcw_res_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [LOC_W-1:0]  cursor_now;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attribute;

  modport source (
    output valid, cursor_now, read_char, read_attribute,
    input  ready
  );

  modport sink (
    input  valid, cursor_now, read_char, read_attribute,
    output ready
  );

endinterface

FILE: rtl/core/tcw_front.sv
module tcw_front #(
  parameter int CELLS = tcw_pkg::CellsDef
) (
  tcw_cmd_if.sink        cmd_i,
  output logic           op_valid_o,
  input  logic           op_ready_i,
  output tcw_pkg::op_t   op_o
);
  import tcw_pkg::*;

  // handshake passes straight to the queue
  assign op_valid_o  = cmd_i.valid;
  assign cmd_i.ready = op_ready_i;

  // decode the command into an operation
  always_comb begin
    op_o.char_code = cmd_i.char_code;
    op_o.attr      = {cmd_i.background, cmd_i.foreground};
    op_o.loc       = cmd_i.cell_location;
    op_o.loc_ok    = ({21'd0, cmd_i.cell_location} < 32'(CELLS));
    unique case (cmd_e'(cmd_i.command))
      CMD_PUT: begin
        op_o.kind = (cmd_i.char_code == CHAR_NEWLINE) ? OP_NEWLINE : OP_PUT;
      end
      CMD_WRITE: begin
        op_o.kind = OP_WRITE;
      end
      CMD_CLEAR: begin
        op_o.kind = OP_CLEAR;
      end
      CMD_READ: begin
        op_o.kind = OP_READ;
      end
      default: begin
        op_o.kind = OP_READ;
      end
    endcase
  end

endmodule

FILE: rtl/core/tcw_queue.sv
module tcw_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  tcw_pkg::op_t push_op_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output tcw_pkg::op_t pop_op_o
);
  import tcw_pkg::*;

  op_t        entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_op_o     = entry_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_op_i;
  end

endmodule

FILE: rtl/core/tcw_back.sv
module tcw_back #(
  parameter int CELLS   = tcw_pkg::CellsDef,
  parameter int COLUMNS = tcw_pkg::ColumnsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  output logic         op_pop_o,
  input  tcw_pkg::op_t op_i,
  tcw_res_if.source    res_o
);
  import tcw_pkg::*;

  localparam int AW     = $clog2(CELLS);
  localparam int PW     = $clog2(CELLS + 1);
  localparam int CW     = $clog2(CELLS + COLUMNS);
  localparam int COLW   = $clog2(COLUMNS);
  localparam int LRS    = (CELLS > COLUMNS) ? (CELLS - COLUMNS) : 0;
  localparam int LRSCOL = LRS % COLUMNS;
  localparam int XW     = (CW > LOC_W) ? CW : LOC_W;
  localparam int LXW    = (AW > LOC_W) ? AW : LOC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_BLANK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [COLW-1:0]   col_q, col_d;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic              rsel_q, rsel_d;

  logic              res_valid_q, res_valid_d;
  logic [LOC_W-1:0]  res_cursor_q, res_cursor_d;
  logic [CHAR_W-1:0] res_char_q, res_char_d;
  logic [ATTR_W-1:0] res_attr_q, res_attr_d;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;
  logic              can_emit, emit;
  logic [CW-1:0]     nxt;
  logic [COLW-1:0]   nxt_col;
  logic [XW-1:0]     cur_x;
  logic [LXW-1:0]    loc_x;
  logic [PW-1:0]     src_back;

  assign can_emit = ~res_valid_q | res_o.ready;
  assign loc_x    = LXW'(op_i.loc);
  assign cur_x    = XW'(cursor_d);
  assign src_back = ptr_q - PW'(COLUMNS);

  // cursor step for put char and newline
  always_comb begin
    if (op_i.kind == OP_NEWLINE) begin
      nxt     = cursor_q + (CW'(COLUMNS) - CW'(col_q));
      nxt_col = '0;
    end else begin
      nxt     = cursor_q + CW'(1);
      nxt_col = (col_q == COLW'(COLUMNS - 1)) ? '0 : col_q + COLW'(1);
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cursor_d = cursor_q;
    col_d    = col_q;
    ptr_d    = ptr_q;
    pend_d   = pend_q;
    wa_d     = wa_q;
    rsel_d   = rsel_q;
    op_pop_o = 1'b0;
    emit     = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = ptr_q[AW-1:0];
    raddr    = ptr_q[AW-1:0];
    wdata    = {ATTR_BLANK, CHAR_SPACE};

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i && can_emit) begin
          op_pop_o = 1'b1;
          case (op_i.kind) inside
            OP_PUT, OP_NEWLINE: begin
              if (op_i.kind == OP_PUT) begin
                we    = 1'b1;
                waddr = cursor_q[AW-1:0];
                wdata = {op_i.attr, op_i.char_code};
              end
              if (nxt >= CW'(CELLS)) begin
                rsel_d = 1'b0;
                pend_d = 1'b0;
                if (LRS > 0) begin
                  state_d = S_COPY;
                  ptr_d   = PW'(COLUMNS);
                end else begin
                  state_d = S_BLANK;
                  ptr_d   = '0;
                end
              end else begin
                cursor_d = nxt;
                col_d    = nxt_col;
                emit     = 1'b1;
              end
            end
            OP_WRITE: begin
              we    = op_i.loc_ok;
              waddr = loc_x[AW-1:0];
              wdata = {op_i.attr, op_i.char_code};
              emit  = 1'b1;
            end
            OP_CLEAR: begin
              state_d = S_CLEAR;
              ptr_d   = '0;
              rsel_d  = 1'b0;
            end
            default: begin
              re      = 1'b1;
              raddr   = loc_x[AW-1:0];
              rsel_d  = op_i.loc_ok;
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        wdata = {ATTR_CLEAR, CHAR_SPACE};
        if (ptr_q == PW'(CELLS - 1)) begin
          cursor_d = '0;
          col_d    = '0;
          state_d  = S_EMIT;
        end else begin
          ptr_d = ptr_q + PW'(1);
        end
      end
      S_COPY: begin
        // read a cell a row below, write it back one row up in the next cycle
        we    = pend_q;
        waddr = wa_q;
        wdata = rd_q;
        if (ptr_q == PW'(CELLS)) begin
          pend_d  = 1'b0;
          ptr_d   = PW'(LRS);
          state_d = S_BLANK;
        end else begin
          re     = 1'b1;
          pend_d = 1'b1;
          wa_d   = src_back[AW-1:0];
          ptr_d  = ptr_q + PW'(1);
        end
      end
      S_BLANK: begin
        we = 1'b1;
        if (ptr_q == PW'(CELLS - 1)) begin
          cursor_d = CW'(LRS);
          col_d    = COLW'(LRSCOL);
          state_d  = S_EMIT;
        end else begin
          ptr_d = ptr_q + PW'(1);
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    res_valid_d  = res_valid_q & ~res_o.ready;
    res_cursor_d = res_cursor_q;
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    if (emit) begin
      res_valid_d  = 1'b1;
      res_cursor_d = cur_x[LOC_W-1:0];
      res_char_d   = (state_q == S_EMIT && rsel_q) ? rd_q[CHAR_W-1:0] : '0;
      res_attr_d   = (state_q == S_EMIT && rsel_q) ? rd_q[CELL_W-1:CHAR_W] : '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      rsel_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      rsel_q      <= rsel_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wa_q         <= wa_d;
    res_cursor_q <= res_cursor_d;
    res_char_q   <= res_char_d;
    res_attr_q   <= res_attr_d;
  end

  // screen store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.cursor_now     = res_cursor_q;
  assign res_o.read_char      = res_char_q;
  assign res_o.read_attribute = res_attr_q;

endmodule

FILE: rtl/core/text_console_writer_with_scroll_unit.sv
// channel  | dir | modport | payload
// cmd_i    | in  | sink    | command, char_code, foreground, background, cell_location
// res_o    | out | source  | cursor_now, read_char, read_attribute
//
// put char and write cell are done straight from idle, read cell goes through the
// registered store read; clear walks the whole store, and a scroll copies rows up
// and blanks the last row through the single write port
// a two-entry queue takes commands while the back end is busy or the result
// register waits; reset is asynchronous, active low, and homes the cursor
module text_console_writer_with_scroll_unit #(
  parameter int CELLS   = tcw_pkg::CellsDef,
  parameter int COLUMNS = tcw_pkg::ColumnsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_cmd_if.sink   cmd_i,
  tcw_res_if.source res_o
);
  import tcw_pkg::*;

  op_t  fr_op, q_op;
  logic fr_valid, fr_ready;
  logic q_valid, q_pop;

  // decode
  tcw_front #(
    .CELLS (CELLS)
  ) u_front (
    .cmd_i      (cmd_i),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready),
    .op_o       (fr_op)
  );

  // decoupling queue
  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_op_i    (fr_op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop),
    .pop_op_o     (q_op)
  );

  // execution and screen store
  tcw_back #(
    .CELLS   (CELLS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_pop_o   (q_pop),
    .op_i       (q_op),
    .res_o      (res_o)
  );

endmodule

FILE: test/tcw_scoreboard_pkg.sv
`timescale 1ns / 1ps

package tcw_scoreboard_pkg;
  import tcw_pkg::*;

  // geometry of the instance under test
  localparam int Cells   = CellsDef;
  localparam int Columns = ColumnsDef;

  typedef struct {
    cmd_e              command;
    logic [CHAR_W-1:0] char_code;
    logic [NIB_W-1:0]  foreground;
    logic [NIB_W-1:0]  background;
    logic [LOC_W-1:0]  cell_location;
  } console_cmd_t;

  typedef struct {
    logic [LOC_W-1:0]  cursor_now;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attribute;
  } console_res_t;

  class console_scoreboard;
    // mirror of the screen store, attribute in the high byte
    logic [CELL_W-1:0] screen [Cells];
    bit                filled [Cells];
    int unsigned       cursor;
    console_res_t      expected_q[$];

    int unsigned errors;
    int unsigned checked;
    int unsigned puts, newlines, writes, clears, reads, scrolls, off_range;

    function new();
      cursor = 0;
      foreach (filled[i]) begin
        filled[i] = 1'b0;
        screen[i] = '0;
      end
    endfunction

    function bit is_filled(int unsigned loc);
      return (loc < Cells) && filled[loc];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void store_cell(int unsigned loc, logic [CHAR_W-1:0] ch,
                             logic [ATTR_W-1:0] attr);
      screen[loc] = {attr, ch};
      filled[loc] = 1'b1;
    endfunction

    // cursor ran off the end: move rows up and blank the last one
    function void scroll_if_past_end();
      int unsigned last_row;
      if (cursor < Cells) return;
      last_row = (Cells > Columns) ? Cells - Columns : 0;
      for (int unsigned a = 0; a < last_row; a++) begin
        screen[a] = screen[a + Columns];
        filled[a] = filled[a + Columns];
      end
      for (int unsigned a = last_row; a < Cells; a++) store_cell(a, CHAR_SPACE, ATTR_BLANK);
      cursor = last_row;
      scrolls++;
    endfunction

    // predict the result of one accepted command transfer
    function void note_command(console_cmd_t c);
      console_res_t      res;
      logic [ATTR_W-1:0] attr;
      attr = {c.background, c.foreground};
      res.read_char = '0;
      res.read_attribute = '0;
      case (c.command)
        CMD_PUT: begin
          puts++;
          if (c.char_code == CHAR_NEWLINE) begin
            newlines++;
            cursor += Columns - (cursor % Columns);
          end else begin
            if (cursor < Cells) store_cell(cursor, c.char_code, attr);
            cursor++;
          end
          scroll_if_past_end();
        end
        CMD_WRITE: begin
          writes++;
          if (c.cell_location < Cells) store_cell(c.cell_location, c.char_code, attr);
          else off_range++;
        end
        CMD_CLEAR: begin
          clears++;
          for (int unsigned a = 0; a < Cells; a++) store_cell(a, CHAR_SPACE, ATTR_CLEAR);
          cursor = 0;
        end
        default: begin
          reads++;
          if (c.cell_location < Cells) begin
            res.read_char = screen[c.cell_location][CHAR_W-1:0];
            res.read_attribute = screen[c.cell_location][CELL_W-1:CHAR_W];
          end else begin
            off_range++;
          end
        end
      endcase
      res.cursor_now = cursor[LOC_W-1:0];
      expected_q.push_back(res);
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_result(console_res_t got);
      console_res_t exp_res;
      checked++;
      if (expected_q.size() == 0) begin
        $error("result with no command outstanding: cursor_now %0d", got.cursor_now);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.cursor_now !== exp_res.cursor_now) begin
        $error("cursor_now: expected %0d, actual %0d", exp_res.cursor_now, got.cursor_now);
        errors++;
      end
      if (got.read_char !== exp_res.read_char) begin
        $error("read_char: expected 0x%02h, actual 0x%02h", exp_res.read_char, got.read_char);
        errors++;
      end
      if (got.read_attribute !== exp_res.read_attribute) begin
        $error("read_attribute: expected 0x%02h, actual 0x%02h",
               exp_res.read_attribute, got.read_attribute);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: test/text_console_writer_with_scroll_unit_tb.sv
`timescale 1ns / 1ps

module text_console_writer_with_scroll_unit_tb;
  import tcw_pkg::*;
  import tcw_scoreboard_pkg::*;

  localparam int RandomItems  = 1030;
  localparam int HoldAfter    = 300;
  localparam int HoldCycles   = 400;
  localparam int DrainCycles  = 40000;
  localparam int MaxLoc       = (1 << LOC_W) - 1;

  logic clk_i;
  logic rst_ni;

  tcw_cmd_if cmd_if ();
  tcw_res_if res_if ();

  console_scoreboard sb;
  int burst_left;

  text_console_writer_with_scroll_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic console_cmd_t make_cmd(cmd_e op, logic [CHAR_W-1:0] ch,
                                            logic [NIB_W-1:0] fg, logic [NIB_W-1:0] bg,
                                            int unsigned loc);
    console_cmd_t c;
    c.command = op;
    c.char_code = ch;
    c.foreground = fg;
    c.background = bg;
    c.cell_location = loc[LOC_W-1:0];
    return c;
  endfunction

  // mostly text with frequent newlines so the screen fills and scrolls
  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int unsigned  sel;
    int unsigned  loc;
    sel = $urandom_range(0, 999);
    c = make_cmd(CMD_PUT, CHAR_W'($urandom), NIB_W'($urandom), NIB_W'($urandom),
                 $urandom_range(0, MaxLoc));
    if (sel < 3) begin
      c.command = CMD_CLEAR;
    end else if (sel < 183) begin
      c.char_code = CHAR_NEWLINE;
    end else if (sel < 550) begin
      c.command = CMD_PUT;
    end else if (sel < 700) begin
      c.command = CMD_WRITE;
      if ($urandom_range(0, 9) == 0) c.cell_location = LOC_W'($urandom_range(Cells, MaxLoc));
      else c.cell_location = LOC_W'($urandom_range(0, Cells - 1));
    end else begin
      c.command = CMD_READ;
      // only cells that hold something are read; off-range reads are always fine
      loc = Cells;
      if ($urandom_range(0, 11) != 0) begin
        for (int t = 0; t < 64; t++) begin
          loc = $urandom_range(0, Cells - 1);
          if (sb.is_filled(loc)) break;
          loc = Cells;
        end
      end
      if (loc >= Cells) loc = $urandom_range(Cells, MaxLoc);
      c.cell_location = loc[LOC_W-1:0];
    end
    return c;
  endfunction

  // sender bursts with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // offer one command and hold it until the transfer
  task automatic send_command(input console_cmd_t c);
    pace();
    cmd_if.valid <= 1'b1;
    cmd_if.command <= c.command;
    cmd_if.char_code <= c.char_code;
    cmd_if.foreground <= c.foreground;
    cmd_if.background <= c.background;
    cmd_if.cell_location <= c.cell_location;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(c);
  endtask

  // edge values, out-of-range locations, newline stored by write cell
  task automatic run_directed();
    send_command(make_cmd(CMD_PUT, 8'h41, 4'hF, 4'hF, 0));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 0));
    send_command(make_cmd(CMD_PUT, CHAR_NEWLINE, 4'h3, 4'hC, 0));
    send_command(make_cmd(CMD_PUT, CHAR_NEWLINE, 4'h0, 4'h0, MaxLoc));
    send_command(make_cmd(CMD_WRITE, 8'hFF, 4'h0, 4'h0, Cells - 1));
    send_command(make_cmd(CMD_READ, 8'hFF, 4'hF, 4'hF, Cells - 1));
    send_command(make_cmd(CMD_WRITE, CHAR_NEWLINE, 4'hA, 4'h5, 5));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 5));
    send_command(make_cmd(CMD_WRITE, 8'h55, 4'h5, 4'hA, MaxLoc));
    send_command(make_cmd(CMD_WRITE, 8'hAA, 4'hF, 4'hF, Cells));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, MaxLoc));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, Cells));
    send_command(make_cmd(CMD_CLEAR, 8'hFF, 4'hF, 4'hF, MaxLoc));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 1234));
    send_command(make_cmd(CMD_PUT, 8'h00, 4'h0, 4'h0, 0));
    send_command(make_cmd(CMD_PUT, 8'hFF, 4'hF, 4'h0, MaxLoc));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 0));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 1));
    send_command(make_cmd(CMD_WRITE, 8'h7F, 4'h0, 4'hF, 0));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 0));
    send_command(make_cmd(CMD_WRITE, 8'h80, 4'h5, 4'hA, 1024));
    send_command(make_cmd(CMD_READ, 8'h00, 4'h0, 4'h0, 1024));
  endtask

  // stimulus and end of run
  initial begin
    int waited;
    sb = new();
    burst_left = 0;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_PUT;
    cmd_if.char_code = '0;
    cmd_if.foreground = '0;
    cmd_if.background = '0;
    cmd_if.cell_location = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int i = 0; i < RandomItems; i++) send_command(random_command());
    cmd_if.valid <= 1'b0;

    // drain, then give a trailing scroll time to show any stray result
    waited = 0;
    while (sb.pending() != 0 && waited < DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Cells + 16) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    $display("covered %0d commands: %0d puts (%0d newlines), %0d writes, %0d clears, %0d reads",
             sb.puts + sb.writes + sb.clears + sb.reads, sb.puts, sb.newlines, sb.writes,
             sb.clears, sb.reads);
    $display("  %0d scrolls, %0d off-range cell accesses, %0d results checked",
             sb.scrolls, sb.off_range, sb.checked);
    if (sb.errors == 0) begin
      $display("text_console_writer_with_scroll_unit regression: pass");
    end else begin
      $display("text_console_writer_with_scroll_unit regression: fail");
    end
    $finish;
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    int phase;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    phase = 0;
    hold_done = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && sb.checked >= HoldAfter) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        phase++;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= (phase % 4 == 0);
        endcase
      end
    end
  end

  // check every result transfer
  always @(posedge clk_i) begin : result_monitor
    console_res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.cursor_now = res_if.cursor_now;
      got.read_char = res_if.read_char;
      got.read_attribute = res_if.read_attribute;
      sb.check_result(got);
    end
  end

  // hard stop
  initial begin
    #100ms;
    $display("text_console_writer_with_scroll_unit regression: fail");
    $finish;
  end

endmodule
